[hdl/glyph_text_blitter_defines.svh]
// Assertion macros used by the glyph text blitter controller.
// No dependencies.
`ifndef GLYPH_TEXT_BLITTER_DEFINES_SVH
`define GLYPH_TEXT_BLITTER_DEFINES_SVH
// check that antecedent implies consequent in the same cycle
`define GTB_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// check that antecedent implies consequent in the next cycle
`define GTB_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[hdl/gtb_pkg.sv]
// Types, codes and the font table for the glyph text blitter.
// No dependencies.
package gtb_pkg;
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W = 10;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_code;
        logic       new_string;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       double_scale;
        logic [9:0] read_index;
    } gtb_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       drawn;
    } gtb_rsp_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load_req;     // latch request, set cursor if new string
        logic clr_wr;       // write zero at sweep address
        logic sweep_inc;
        logic rd_issue;     // memory read at current address
        logic rmw_wr;       // write back ORed byte
        logic step_inc;     // next glyph byte step
        logic commit;       // form response, advance cursor if drawn
        logic rsp_take;
    } gtb_cmd_t;

    typedef struct packed {
        logic [1:0] operation;
        logic       fits;
        logic       sweep_last;
        logic       step_last;
        logic       rsp_valid;
    } gtb_sts_t;

    function automatic logic [5:0] font_slot(input logic [7:0] c);
        logic [5:0] s;
        s = 6'd41;
        if (c >= 8'h30 && c <= 8'h39) s = 6'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h5A) s = 6'(c - 8'h41 + 8'd10);
        else if (c == 8'h2B) s = 6'd36;
        else if (c == 8'h2D) s = 6'd37;
        else if (c == 8'h2E) s = 6'd38;
        else if (c == 8'h2F) s = 6'd39;
        else if (c == 8'h3A) s = 6'd40;
        return s;
    endfunction

    function automatic logic [39:0] font_row(input logic [5:0] s);
        logic [39:0] g;
        case (s)
            6'd0:  g = 40'h3E5149453E;
            6'd1:  g = 40'h00427F4000;
            6'd2:  g = 40'h4261514946;
            6'd3:  g = 40'h2141454B31;
            6'd4:  g = 40'h1814127F10;
            6'd5:  g = 40'h2745454539;
            6'd6:  g = 40'h3C4A494930;
            6'd7:  g = 40'h0171090503;
            6'd8:  g = 40'h3649494936;
            6'd9:  g = 40'h064949291E;
            6'd10: g = 40'h7E1111117E;
            6'd11: g = 40'h7F49494936;
            6'd12: g = 40'h3E41414122;
            6'd13: g = 40'h7F4141221C;
            6'd14: g = 40'h7F49494941;
            6'd15: g = 40'h7F09090901;
            6'd16: g = 40'h3E4149497A;
            6'd17: g = 40'h7F0808087F;
            6'd18: g = 40'h00417F4100;
            6'd19: g = 40'h2040413F01;
            6'd20: g = 40'h7F08142241;
            6'd21: g = 40'h7F40404040;
            6'd22: g = 40'h7F020C027F;
            6'd23: g = 40'h7F0408107F;
            6'd24: g = 40'h3E4141413E;
            6'd25: g = 40'h7F09090906;
            6'd26: g = 40'h3E4151215E;
            6'd27: g = 40'h7F09192946;
            6'd28: g = 40'h4649494931;
            6'd29: g = 40'h01017F0101;
            6'd30: g = 40'h3F4040403F;
            6'd31: g = 40'h1F2040201F;
            6'd32: g = 40'h3F4038403F;
            6'd33: g = 40'h6314081463;
            6'd34: g = 40'h0708700807;
            6'd35: g = 40'h6151494543;
            6'd36: g = 40'h08083E0808;
            6'd37: g = 40'h0808080808;
            6'd38: g = 40'h0060600000;
            6'd39: g = 40'h2010080402;
            6'd40: g = 40'h0036360000;
            default: g = 40'h0;
        endcase
        return g;
    endfunction
endpackage

[hdl/gtb_if.sv]
// Valid/ready channel used for requests and responses.
// Generic over the payload type.
interface gtb_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hdl/glyph_text_blitter.sv]
// channel | dir | payload
// req     | in  | operation, char_code, new_string, pos_x, pos_y, double_scale, read_index
// rsp     | out | read_data, drawn
// All operations go through the single frame store port: a draw reads then writes each
//   glyph byte (two pages per column, three at double scale); a clear writes every address.
// Reset clears control and cursor, then a sweep over all 1024 addresses zeroes the store
//   before the first request is taken.
// A pending response is held until taken; a new request waits for it to drain.
module glyph_text_blitter
    import gtb_pkg::*;
#(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64
)
(
    input  logic clk,
    input  logic rst_n,
    gtb_if.sink   req,
    gtb_if.source rsp
);
    gtb_cmd_t cmd;
    gtb_sts_t sts;
    gtb_rsp_t rsp_data;

    gtb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_ready(rsp.ready), .sts(sts), .cmd(cmd)
    );

    gtb_datapath #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_dp (
        .clk(clk), .rst_n(rst_n), .req(req.payload), .cmd(cmd), .sts(sts), .rsp(rsp_data)
    );

    assign rsp.valid   = sts.rsp_valid;
    assign rsp.payload = rsp_data;
endmodule

[hdl/gtb_ctrl.sv]
// Sequencer for the glyph text blitter: clear sweep, glyph RMW, read.
// Depends on gtb_pkg and the assertion macros header.
`include "glyph_text_blitter_defines.svh"
module gtb_ctrl
    import gtb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_ready,
    input  gtb_sts_t sts,
    output gtb_cmd_t cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_CLR   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_RDATA = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;
    localparam logic [2:0] S_INIT  = 3'd7;

    logic [2:0] state_reg, state_next;

    // response register parts the two sides; take a new request once it drains
    assign in_ready = (state_reg == S_IDLE) && (!sts.rsp_valid || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.rsp_take = sts.rsp_valid && out_ready;
        unique case (state_reg)
            S_INIT:
            begin
                // zero the store after reset, no response
                cmd.clr_wr = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (sts.sweep_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load_req = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (sts.operation)
                    OP_CLEAR: state_next = S_CLR;
                    OP_DRAW:  state_next = sts.fits ? S_RD : S_DONE;
                    OP_READ:
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next = S_RDATA;
                    end
                    default:  state_next = S_DONE;
                endcase
            end
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (sts.sweep_last) state_next = S_DONE;
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.rmw_wr = 1'b1;
                cmd.step_inc = 1'b1;
                state_next = sts.step_last ? S_DONE : S_RD;
            end
            S_RDATA: state_next = S_DONE;
            S_DONE:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_INIT;
        else        state_reg <= state_next;
    end

    `GTB_ASSERT_IMP(a_accept_idle, clk, rst_n, cmd.load_req, state_reg == S_IDLE)
    `GTB_ASSERT_NEXT(a_load_dec, clk, rst_n, cmd.load_req, state_reg == S_DEC)
    `GTB_ASSERT_NEXT(a_rd_then_wr, clk, rst_n, state_reg == S_RD, state_reg == S_WR)
    `GTB_ASSERT_IMP(a_commit_room, clk, rst_n, cmd.commit, !sts.rsp_valid || cmd.rsp_take)
endmodule

[hdl/gtb_datapath.sv]
// Frame store, cursor, font lookup and response register.
// Depends on gtb_pkg.
module gtb_datapath
    import gtb_pkg::*;
#(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  gtb_req_t req,
    input  gtb_cmd_t cmd,
    output gtb_sts_t sts,
    output gtb_rsp_t rsp
);
    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    gtb_req_t   req_reg;
    logic [7:0] col_reg, row_reg;
    logic       dbl_reg;
    logic [ADDR_W-1:0] sweep_reg;
    // step: column step 0..9 (double) / 0..4, and page offset 0..2 / 0..1
    logic [3:0] sc_reg;
    logic [1:0] sp_reg;
    gtb_rsp_t   rsp_reg;
    logic       rsp_valid_reg;
    logic [39:0] glyph_reg;

    logic       fits;
    logic [3:0] sc_max;
    logic [1:0] sp_max;
    logic [7:0] px, gcol, row_base_pg;
    logic [7:0] mask;
    logic       addr_ok;
    logic [ADDR_W-1:0] rmw_addr;
    logic [7:0] yy;
    logic [2:0] gy;

    assign fits = ({1'b0, col_reg} + (dbl_reg ? 9'd9 : 9'd5)) < 9'(FRAME_WIDTH);
    assign sc_max = dbl_reg ? 4'd9 : 4'd4;
    assign sp_max = dbl_reg ? 2'd2 : 2'd1;

    assign px = col_reg + 8'(sc_reg);
    // glyph column for this pixel column
    assign gcol = dbl_reg ? 8'(sc_reg[3:1]) : 8'(sc_reg);
    assign row_base_pg = 8'({3'b0, row_reg[7:3]} + 8'(sp_reg));

    // build bit mask for the page: each bit's pixel row y maps to font row
    always_comb
    begin
        logic [7:0] gbyte;
        logic [7:0] ypix;
        gbyte = glyph_reg[8'd39 - gcol*8 -: 8];
        mask = '0;
        yy = '0;
        gy = '0;
        ypix = '0;
        for (int b = 0; b < 8; b++)
        begin
            ypix = 8'({row_base_pg[4:0], 3'(b)});
            yy = ypix - row_reg;   // offset from row base
            if (dbl_reg)
            begin
                gy = yy[3:1];
                if (yy < 8'd14 && gbyte[gy] && ({1'b0, ypix} < 9'(FRAME_HEIGHT)))
                    mask[b] = 1'b1;
            end
            else
            begin
                gy = yy[2:0];
                if (yy < 8'd7 && gbyte[gy] && ({1'b0, ypix} < 9'(FRAME_HEIGHT)))
                    mask[b] = 1'b1;
            end
        end
    end

    // pages wrap at 32 (row mod 256); clip by pixel row limit and width
    assign addr_ok = (px < 8'(FRAME_WIDTH)) &&
                     ({row_base_pg[4:0], 3'b0} < 9'(FRAME_HEIGHT)) &&
                     (32'(row_base_pg[4:0]) * FRAME_WIDTH + 32'(px) < STORE_DEPTH);
    assign rmw_addr = ADDR_W'(32'(row_base_pg[4:0]) * FRAME_WIDTH + 32'(px));

    always_ff @(posedge clk)
    begin
        if (cmd.load_req) req_reg <= req;
        if (cmd.clr_wr) mem[sweep_reg] <= '0;
        if (cmd.rmw_wr && addr_ok) mem[rmw_addr] <= rdata_reg | mask;
        if (cmd.rd_issue)
            rdata_reg <= mem[(req_reg.operation == OP_READ) ? req_reg.read_index : rmw_addr];
        if (cmd.load_req)
        begin
            // glyph lookup registered off the incoming code
            glyph_reg <= font_row(font_slot(req.char_code));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0; row_reg <= '0; dbl_reg <= 1'b0;
            sweep_reg <= '0; sc_reg <= '0; sp_reg <= '0;
            rsp_valid_reg <= 1'b0; rsp_reg <= '0;
        end
        else
        begin
            if (cmd.load_req)
            begin
                sweep_reg <= '0; sc_reg <= '0; sp_reg <= '0;
                if (req.operation == OP_DRAW && req.new_string)
                begin
                    col_reg <= req.pos_x; row_reg <= req.pos_y; dbl_reg <= req.double_scale;
                end
            end
            if (cmd.sweep_inc) sweep_reg <= sweep_reg + ADDR_W'(1);
            if (cmd.step_inc)
            begin
                if (sp_reg == sp_max)
                begin
                    sp_reg <= '0;
                    sc_reg <= sc_reg + 4'd1;
                end
                else sp_reg <= sp_reg + 2'd1;
            end
            if (cmd.rsp_take) rsp_valid_reg <= 1'b0;
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg.read_data <= (req_reg.operation == OP_READ) ? rdata_reg : 8'd0;
                rsp_reg.drawn <= (req_reg.operation == OP_DRAW) && fits;
                if (req_reg.operation == OP_DRAW && fits)
                    col_reg <= col_reg + (dbl_reg ? 8'd12 : 8'd6);
            end
        end
    end

    assign sts.operation  = req_reg.operation;
    assign sts.fits       = fits;
    assign sts.sweep_last = (sweep_reg == ADDR_W'(STORE_DEPTH - 1));
    assign sts.step_last  = (sc_reg == sc_max) && (sp_reg == sp_max);
    assign sts.rsp_valid  = rsp_valid_reg;
    assign rsp = rsp_reg;
endmodule

[tb/sv/glyph_text_blitter_test.sv]
// Self-checking testbench for glyph_text_blitter: directed table, then random requests.
// Depends on gtb_pkg and gtb_if; responses are checked against a frame-store shadow model.
`timescale 1ns / 1ps

module glyph_text_blitter_test;
    import gtb_pkg::*;

    localparam int WIDTH      = 128;
    localparam int HEIGHT     = 64;
    localparam int NUM_RANDOM = 1000;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        gtb_req_t rq;
        bit       typed;
        gtb_rsp_t want;
    } table_row_t;

    // 5x7 glyphs, first column in the top byte, LSB is the top pixel
    localparam logic [39:0] GLYPHS [42] = '{
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
        40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100, 40'h2040413F01,
        40'h7F08142241, 40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F,
        40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543,
        40'h08083E0808, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h0036360000, 40'h0000000000
    };

    logic clk;
    logic rst_n;

    gtb_if #(.payload_t(gtb_req_t)) req_ch (clk);
    gtb_if #(.payload_t(gtb_rsp_t)) rsp_ch (clk);

    glyph_text_blitter #(.FRAME_WIDTH(WIDTH), .FRAME_HEIGHT(HEIGHT)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // shadow of the block state
    logic [7:0] shadow_frame [STORE_DEPTH];
    logic [7:0] shadow_col;
    logic [7:0] shadow_row;
    logic       shadow_double;

    gtb_rsp_t pending_rsp[$];
    int       mismatches;
    int       cycles;
    int       sent;
    int       drawn_count;
    int       read_count;
    int       clear_count;
    bit       calm;
    string    charset;
    table_row_t rows[$];

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int glyph_index(input logic [7:0] c);
        int i;
        for (i = 0; i < charset.len(); i++)
        begin
            if (charset[i] == c)
                return i;
        end
        return 41;
    endfunction

    function automatic void plot(input int x, input int y);
        int idx;
        x = x & 255;
        y = y & 255;
        if (x >= WIDTH || y >= HEIGHT)
            return;
        idx = (y / 8) * WIDTH + x;
        if (idx >= STORE_DEPTH)
            return;
        shadow_frame[idx] = shadow_frame[idx] | (8'd1 << (y % 8));
    endfunction

    function automatic gtb_rsp_t render_request(input gtb_req_t r);
        gtb_rsp_t res;
        logic [39:0] g;
        logic [7:0] column_bits;
        int gx;
        int gy;
        int reach;
        res = '0;
        case (r.operation)
            OP_CLEAR:
            begin
                for (int i = 0; i < STORE_DEPTH; i++)
                    shadow_frame[i] = 8'd0;
            end
            OP_DRAW:
            begin
                if (r.new_string)
                begin
                    shadow_col    = r.pos_x;
                    shadow_row    = r.pos_y;
                    shadow_double = r.double_scale;
                end
                reach = shadow_double ? 9 : 5;
                if (int'(shadow_col) + reach < WIDTH)
                begin
                    g = GLYPHS[glyph_index(r.char_code)];
                    for (gx = 0; gx < 5; gx++)
                    begin
                        column_bits = g[39 - 8 * gx -: 8];
                        for (gy = 0; gy < 7; gy++)
                        begin
                            if (!column_bits[gy])
                                continue;
                            if (shadow_double)
                            begin
                                plot(shadow_col + gx * 2, shadow_row + gy * 2);
                                plot(shadow_col + gx * 2, shadow_row + gy * 2 + 1);
                                plot(shadow_col + gx * 2 + 1, shadow_row + gy * 2);
                                plot(shadow_col + gx * 2 + 1, shadow_row + gy * 2 + 1);
                            end
                            else
                                plot(shadow_col + gx, shadow_row + gy);
                        end
                    end
                    shadow_col = shadow_col + (shadow_double ? 8'd12 : 8'd6);
                    res.drawn = 1'b1;
                end
            end
            OP_READ:
                res.read_data = shadow_frame[r.read_index];
            default:
                res = '0;
        endcase
        return res;
    endfunction

    function automatic gtb_req_t make_req(input logic [1:0] op, input logic [7:0] code,
                                          input logic ns, input logic [7:0] x,
                                          input logic [7:0] y, input logic ds,
                                          input logic [9:0] idx);
        gtb_req_t r;
        r.operation    = op;
        r.char_code    = code;
        r.new_string   = ns;
        r.pos_x        = x;
        r.pos_y        = y;
        r.double_scale = ds;
        r.read_index   = idx;
        return r;
    endfunction

    function automatic void add_row(input gtb_req_t r, input bit typed,
                                    input logic [7:0] data, input logic drawn);
        table_row_t t;
        t.rq = r;
        t.typed = typed;
        t.want.read_data = data;
        t.want.drawn = drawn;
        rows.push_back(t);
    endfunction

    function automatic int pick_delay();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic gtb_req_t random_req();
        gtb_req_t r;
        int sel;
        r = '0;
        r.new_string   = 1'($urandom_range(0, 1));
        r.pos_x        = 8'($urandom_range(0, 255));
        r.pos_y        = 8'($urandom_range(0, 255));
        r.double_scale = 1'($urandom_range(0, 1));
        r.read_index   = 10'($urandom_range(0, 1023));
        r.char_code    = 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (sel < 1)
            r.operation = OP_CLEAR;
        else if (sel < 3)
            r.operation = OP_UNUSED;
        else if (sel < 28)
        begin
            r.operation = OP_READ;
            // mostly look where text lands
            if ($urandom_range(0, 3) != 0)
                r.read_index = 10'($urandom_range(0, 7) * WIDTH +
                                   $urandom_range(0, WIDTH - 1));
        end
        else
        begin
            r.operation = OP_DRAW;
            r.new_string = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 7)
            begin
                r.pos_x = 8'($urandom_range(0, 130));
                r.pos_y = 8'($urandom_range(0, 70));
            end
            if ($urandom_range(0, 9) < 8)
                r.char_code = charset[$urandom_range(0, charset.len() - 1)];
        end
        return r;
    endfunction

    task automatic send(input gtb_req_t r, input bit typed, input gtb_rsp_t want);
        int gap;
        gtb_rsp_t predicted;
        gap = pick_delay();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = render_request(r);
        pending_rsp.push_back(typed ? want : predicted);
        sent++;
        case (r.operation)
            OP_CLEAR: clear_count++;
            OP_READ:  read_count++;
            OP_DRAW:  drawn_count += predicted.drawn;
            default:  ;
        endcase
    endtask

    // response side
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_delay();
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t unexpected response read_data %h drawn %b", $time,
                         rsp_ch.payload.read_data, rsp_ch.payload.drawn);
                mismatches++;
            end
            else
            begin
                gtb_rsp_t want;
                want = pending_rsp.pop_front();
                if (want.read_data !== rsp_ch.payload.read_data)
                begin
                    $display("%0t read_data expected %h actual %h", $time,
                             want.read_data, rsp_ch.payload.read_data);
                    mismatches++;
                end
                if (want.drawn !== rsp_ch.payload.drawn)
                begin
                    $display("%0t drawn expected %b actual %b", $time,
                             want.drawn, rsp_ch.payload.drawn);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycles, pending_rsp.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        gtb_rsp_t none;
        int settle;
        none = '0;
        charset = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ+-./:";
        mismatches = 0;
        cycles = 0;
        sent = 0;
        drawn_count = 0;
        read_count = 0;
        clear_count = 0;
        calm = 1'b0;
        shadow_col = 8'd0;
        shadow_row = 8'd0;
        shadow_double = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
            shadow_frame[i] = 8'd0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;

        // store comes up zero after reset; a clear with every field at its extreme
        add_row(make_req(OP_READ, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 10'd0), 1'b1, 8'h00, 1'b0);
        add_row(make_req(OP_READ, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 10'h3FF), 1'b1, 8'h00, 1'b0);
        add_row(make_req(OP_CLEAR, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1, 10'h3FF), 1'b1, 8'h00, 1'b0);
        add_row(make_req(OP_DRAW, "0", 1'b1, 8'd0, 8'd0, 1'b0, 10'd0), 1'b1, 8'h00, 1'b1);
        add_row(make_req(OP_READ, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 10'd0), 1'b1, 8'h3E, 1'b0);
        add_row(make_req(OP_DRAW, "A", 1'b0, 8'd0, 8'd0, 1'b0, 10'd0), 1'b0, 8'h00, 1'b0);
        // last column that fits, then one past it; the rest of the string is skipped
        add_row(make_req(OP_DRAW, "W", 1'b1, 8'd122, 8'd3, 1'b0, 10'd0), 1'b1, 8'h00, 1'b1);
        add_row(make_req(OP_DRAW, "8", 1'b1, 8'd123, 8'd3, 1'b0, 10'd0), 1'b1, 8'h00, 1'b0);
        add_row(make_req(OP_DRAW, "8", 1'b0, 8'd0, 8'd0, 1'b0, 10'd0), 1'b1, 8'h00, 1'b0);
        // double scale at the right edge, bottom rows clipped
        add_row(make_req(OP_DRAW, "M", 1'b1, 8'd118, 8'd60, 1'b1, 10'd0), 1'b1, 8'h00, 1'b1);
        add_row(make_req(OP_DRAW, "M", 1'b1, 8'd119, 8'd60, 1'b1, 10'd0), 1'b1, 8'h00, 1'b0);
        add_row(make_req(OP_DRAW, "X", 1'b1, 8'd250, 8'd0, 1'b1, 10'd0), 1'b1, 8'h00, 1'b0);
        // row wraps past 255 back to the top
        add_row(make_req(OP_DRAW, "B", 1'b1, 8'd40, 8'd255, 1'b0, 10'd0), 1'b0, 8'h00, 1'b0);
        add_row(make_req(OP_DRAW, " ", 1'b0, 8'd0, 8'd0, 1'b0, 10'd0), 1'b0, 8'h00, 1'b0);
        add_row(make_req(OP_DRAW, "+", 1'b1, 8'd10, 8'd20, 1'b1, 10'd0), 1'b0, 8'h00, 1'b0);
        add_row(make_req(OP_DRAW, "-", 1'b0, 8'd0, 8'd0, 1'b0, 10'd0), 1'b0, 8'h00, 1'b0);
        add_row(make_req(OP_DRAW, ".", 1'b0, 8'd0, 8'd0, 1'b0, 10'd0), 1'b0, 8'h00, 1'b0);
        add_row(make_req(OP_DRAW, "/", 1'b0, 8'd0, 8'd0, 1'b0, 10'd0), 1'b0, 8'h00, 1'b0);
        add_row(make_req(OP_DRAW, ":", 1'b1, 8'd60, 8'd5, 1'b0, 10'd0), 1'b0, 8'h00, 1'b0);
        add_row(make_req(OP_DRAW, "Z", 1'b0, 8'd0, 8'd0, 1'b0, 10'd0), 1'b0, 8'h00, 1'b0);
        add_row(make_req(OP_DRAW, 8'hFF, 1'b0, 8'd0, 8'd0, 1'b0, 10'd0), 1'b0, 8'h00, 1'b0);
        add_row(make_req(OP_UNUSED, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1, 10'h3FF), 1'b1, 8'h00, 1'b0);
        add_row(make_req(OP_READ, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1, 10'd69), 1'b0, 8'h00, 1'b0);
        add_row(make_req(OP_CLEAR, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 10'd0), 1'b1, 8'h00, 1'b0);
        add_row(make_req(OP_READ, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 10'd0), 1'b1, 8'h00, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send(rows[i].rq, rows[i].typed, rows[i].want);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (n == NUM_RANDOM / 2)
            begin
                // hold off until the block has drained
                req_ch.valid <= 1'b0;
                while (pending_rsp.size() != 0)
                    @(posedge clk);
            end
            send(random_req(), 1'b0, none);
        end
        req_ch.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        settle = 0;
        while (settle < 80)
        begin
            @(posedge clk);
            settle++;
        end

        $display("%0d requests: %0d glyphs drawn, %0d byte reads, %0d clears",
                 sent, drawn_count, read_count, clear_count);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
